// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty when compiled for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== hdl/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Widths and interface types of the trial division primality tester.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // width of the tested value
  localparam int VALUE_WIDTH = 32;
  // bit counter of the serial divider
  localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);
  // trial divisor never exceeds floor(sqrt(value)) + 1
  localparam int DIV_WIDTH = VALUE_WIDTH / 2 + 1;

  // request to the shared divider
  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } div_req_t;

  // answer from the shared divider
  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [VALUE_WIDTH-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hdl/ptd_divider.sv =====
// ----------------------------------------------------------------------------
// ptd_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptd_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptd_pkg::div_req_t req_i,
  output ptd_pkg::div_rsp_t rsp_o
);

  logic [ptd_pkg::VALUE_WIDTH-1:0] quo_q;
  logic [ptd_pkg::VALUE_WIDTH-1:0] rem_q;
  logic [ptd_pkg::VALUE_WIDTH-1:0] dvs_q;
  logic [ptd_pkg::CNT_WIDTH-1:0]   cnt_q;
  logic                            active_q;
  logic                            done_q;

  logic [ptd_pkg::VALUE_WIDTH:0]   rem_shift;
  logic [ptd_pkg::VALUE_WIDTH:0]   diff;
  logic                            fits;
  logic                            last;

  // shift in next dividend bit and trial subtract
  always_comb begin
    rem_shift = {rem_q, quo_q[ptd_pkg::VALUE_WIDTH-1]};
    diff      = rem_shift - {1'b0, dvs_q};
    fits      = ~diff[ptd_pkg::VALUE_WIDTH];
    last      = (cnt_q == ptd_pkg::CNT_WIDTH'(ptd_pkg::VALUE_WIDTH - 1));
  end

  // control: bit counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (active_q) begin
      quo_q <= {quo_q[ptd_pkg::VALUE_WIDTH-2:0], fits};
      rem_q <= fits ? diff[ptd_pkg::VALUE_WIDTH-1:0] : rem_shift[ptd_pkg::VALUE_WIDTH-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  // a new division is only launched on an idle divider
  `ASSERT_NEVER(a_start_idle, clk_i, rst_ni, req_i.start && active_q, "divider restarted while active")
  // completion comes only after the last bit step
  `ASSERT_PROP(a_done_after_last, clk_i, rst_ni, done_q |-> $past(active_q && last), "done without last step")

endmodule

// ===== hdl/primality_trial_division.sv =====
// ----------------------------------------------------------------------------
// primality_trial_division
// Trial division primality test of one signed value per command.
// ----------------------------------------------------------------------------
// Usage: drive number_i and raise start while busy is low; the value is taken
// at that clock edge. busy stays high until the answer is known; it stays
// low for negative values, zero and one. The answer appears on is_prime_o
// for exactly one cycle with done_o high; the receiver takes it then and
// cannot hold it off. A new command may be given in the cycle done_o is high.
// Negative values, zero and one are answered in the cycle after start is taken.
// Other values run trial divisors 2, 3, ... until the divisor exceeds
// value / divisor or divides the value; each trial is one full division on
// the one shared bit-serial divider that produces both quotient and
// remainder. One command is in progress at a time.
// Reset: asynchronous and active low; it drops any command in progress and
// leaves the block idle with no pending result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module primality_trial_division (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ptd_pkg::VALUE_WIDTH-1:0] number_i,
  output logic                                   done_o,
  output logic                                   is_prime_o
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [ptd_pkg::VALUE_WIDTH-1:0] value_q, value_d;
  logic [ptd_pkg::DIV_WIDTH-1:0]   dvs_q, dvs_d;
  logic                            done_q, done_d;
  logic                            prime_q, prime_d;

  ptd_pkg::div_req_t div_req;
  ptd_pkg::div_rsp_t div_rsp;

  logic accept;
  logic trivial;
  logic past_bound;

  assign accept     = start && (state_q == S_IDLE);
  // negative, zero or one is never prime
  assign trivial    = number_i[ptd_pkg::VALUE_WIDTH-1] ||
                      (number_i[ptd_pkg::VALUE_WIDTH-1:1] == '0);
  assign past_bound = ptd_pkg::VALUE_WIDTH'(dvs_q) > div_rsp.quotient;

  // shared divider
  ptd_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    div_req.start    = (state_q == S_LOAD);
    div_req.dividend = value_q;
    div_req.divisor  = ptd_pkg::VALUE_WIDTH'(dvs_q);
  end

  // trial sequencer
  always_comb begin
    state_d = state_q;
    value_d = value_q;
    dvs_d   = dvs_q;
    done_d  = 1'b0;
    prime_d = prime_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          value_d = number_i;
          dvs_d   = ptd_pkg::DIV_WIDTH'(2);
          if (trivial) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (past_bound) begin
            done_d  = 1'b1;
            prime_d = 1'b1;
            state_d = S_IDLE;
          end else if (div_rsp.remainder == '0) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
            state_d = S_IDLE;
          end else begin
            dvs_d   = dvs_q + 1'b1;
            state_d = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    dvs_q   <= dvs_d;
    prime_q <= prime_d;
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

  // divider answers only while a trial is pending
  `ASSERT_PROP(a_rsp_in_wait, clk_i, rst_ni, div_rsp.done |-> (state_q == S_WAIT), "divider answer outside a trial")
  // trial divisor never drops below two during a test
  `ASSERT_PROP(a_dvs_min, clk_i, rst_ni, (state_q == S_WAIT) |-> (dvs_q >= ptd_pkg::DIV_WIDTH'(2)), "trial divisor below two")
  // a negative value is rejected in the next cycle
  `ASSERT_PROP(a_neg_fast, clk_i, rst_ni, (accept && number_i[ptd_pkg::VALUE_WIDTH-1]) |=> (done_o && !is_prime_o), "negative value not rejected at once")

endmodule
